### hw/rtl/pad_pkg.sv
`timescale 1ns / 1ps

package pad_pkg;

    localparam int QLEN_BITS  = 10;
    localparam int PROB_BITS  = 16;
    localparam int GAIN_FRAC  = 16;
    localparam int INV_FRAC   = 24;
    localparam int INV_W      = 25;
    localparam int GAIN_W     = 18;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = INV_W;

    localparam int P_W    = PROB_BITS + 1;
    localparam int E_W    = PROB_BITS + 5;
    localparam int DE_W   = E_W + 1;
    localparam int DIFF_W = QLEN_BITS + 1;
    localparam int INT_W  = PROB_BITS + 1;
    localparam int SUM_W  = PROB_BITS + 9;
    localparam int TEN_W  = QLEN_BITS + 4;
    localparam int MA_W   = INV_W + 1;
    localparam int MB_W   = (DE_W > DIFF_W) ? DE_W : DIFF_W;
    localparam int PROD_W = MA_W + MB_W;

    localparam int INV_SHIFT = INV_FRAC - PROB_BITS;
    localparam int DIV_SHIFT = PROB_BITS + 4;

    localparam longint DIV_MUL  = (longint'(1) << DIV_SHIFT) / 10 + 1;
    localparam longint ERR_SAT  = longint'(8) << PROB_BITS;
    localparam longint INT_SAT  = (longint'(2) << PROB_BITS) / 5;
    localparam longint PROB_ONE = longint'(1) << PROB_BITS;

    localparam logic signed [PROD_W-1:0] ERR_HI = PROD_W'(ERR_SAT);
    localparam logic signed [PROD_W-1:0] ERR_LO = PROD_W'(-ERR_SAT);
    localparam logic signed [SUM_W-1:0]  INT_HI = SUM_W'(INT_SAT);
    localparam logic signed [SUM_W-1:0]  INT_LO = SUM_W'(-INT_SAT);
    localparam logic signed [SUM_W-1:0]  PROB_ONE_S = SUM_W'(PROB_ONE);
    localparam logic [P_W-1:0]           PROB_ONE_P = P_W'(PROB_ONE);
    localparam logic signed [MA_W-1:0]   DIV_MUL_C  = MA_W'(DIV_MUL);

    localparam logic signed [PROD_W-1:0] INV_BIAS  = PROD_W'((longint'(1) << INV_SHIFT) - 1);
    localparam logic signed [PROD_W-1:0] GAIN_BIAS = PROD_W'((longint'(1) << GAIN_FRAC) - 1);
    localparam logic signed [PROD_W-1:0] DIV_BIAS  = PROD_W'((longint'(1) << DIV_SHIFT) - 1);

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_ARRIVAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_EARLY = 2'd1,
        CAUSE_TAIL  = 2'd2
    } drop_cause_t;

    typedef enum logic [IDX_W-1:0] {
        REG_QUEUE_REF   = 3'd0,
        REG_INVERSE_REF = 3'd1,
        REG_KP_GAIN     = 3'd2,
        REG_KI_TS_GAIN  = 3'd3,
        REG_KD_TS_GAIN  = 3'd4,
        REG_QUEUE_LIMIT = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        SH_INV  = 2'd0,
        SH_GAIN = 2'd1,
        SH_DIV  = 2'd2
    } shift_sel_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_ME,
        T_PE,
        T_MI,
        T_MP,
        T_MD,
        T_PD,
        T_MQ,
        T_PQ
    } tick_state_t;

    typedef struct packed {
        logic [QLEN_BITS-1:0] queue_ref;
        logic [INV_W-1:0]     inverse_ref;
        logic [GAIN_W-1:0]    kp_gain;
        logic [GAIN_W-1:0]    ki_ts_gain;
        logic [GAIN_W-1:0]    kd_over_ts_gain;
        logic [QLEN_BITS-1:0] queue_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        queue_ref:       QLEN_BITS'(500),
        inverse_ref:     INV_W'(33554),
        kp_gain:         GAIN_W'(19661),
        ki_ts_gain:      GAIN_W'(328),
        kd_over_ts_gain: GAIN_W'(52429),
        queue_limit:     QLEN_BITS'(1000)
    };

    typedef struct packed {
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
        shift_sel_t             sh;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic                 ref_write;
        logic [QLEN_BITS-1:0] queue_len;
    } tick_ctl_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [P_W-1:0] dp;
        logic [P_W-1:0] dp_new;
    } tick_sts_t;

    function automatic logic [TEN_W-1:0] times_ten(input logic [QLEN_BITS-1:0] v);
        logic [TEN_W-1:0] w;
        w = TEN_W'(v);
        return (w << 3) + (w << 1);
    endfunction

endpackage

### hw/rtl/pad_ifs.sv
`timescale 1ns / 1ps

interface pad_req_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [pad_pkg::QLEN_BITS-1:0]  queue_len;
    logic [pad_pkg::PROB_BITS-1:0]  random_value;

    modport source (output valid, operation, queue_len, random_value, input ready);
    modport sink (input valid, operation, queue_len, random_value, output ready);
endinterface

interface pad_res_if;
    logic                      valid;
    logic                      ready;
    logic                      drop;
    logic [1:0]                drop_cause;
    logic [pad_pkg::P_W-1:0]   drop_rate;

    modport source (output valid, drop, drop_cause, drop_rate, input ready);
    modport sink (input valid, drop, drop_cause, drop_rate, output ready);
endinterface

interface pad_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pad_pkg::IDX_W-1:0]        index;
    logic [pad_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pid_aqm_drop_controller.sv
`timescale 1ns / 1ps

// PID active queue manager with random early drop and a hard tail limit.
// Channels: req carries operation, queue_len and random_value; result carries
// drop, drop_cause and drop_rate; cfg writes one of six registers by index
// (0 queue_ref, 1 inverse_ref, 2 kp_gain, 3 ki_ts_gain, 4 kd_over_ts_gain,
// 5 queue_limit). cfg is always ready; writing queue_ref clears the integral
// and the previous error. Write cfg only while no request is in flight.
// A packet arrival is a single compare: its result is registered in the cycle after
// acceptance, and arrivals run at one per cycle while result is taken and no tick is busy.
// A control tick walks a shared multiplier through eight steps (error, integral,
// proportional, derivative, divide by ten); its result is registered when the last
// step ends, and req.ready stays low meanwhile.
// Each request gives exactly one result, in order.
// Reset loads the register defaults and zeroes the integral, previous error
// and drop probability. When result stalls, the result register holds and
// req.ready drops until it is taken.

module pid_aqm_drop_controller (
    input  logic       clk,
    input  logic       rst_n,
    pad_req_if.sink    req,
    pad_res_if.source  result,
    pad_cfg_if.sink    cfg
);
    import pad_pkg::*;

    cfg_t      cfg_q;
    logic      ref_write;
    tick_ctl_t ctl;
    tick_sts_t sts;

    logic           accept;
    logic           early;
    logic           tail;
    logic           valid_reg, valid_next;
    logic           drop_reg, drop_next;
    drop_cause_t    cause_reg, cause_next;
    logic [P_W-1:0] prob_reg, prob_next;

    pad_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_q     (cfg_q),
        .ref_write (ref_write)
    );

    pad_tick_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg_q (cfg_q),
        .ctl   (ctl),
        .sts   (sts)
    );

    assign req.ready = !sts.busy && (!valid_reg || result.ready);
    assign accept    = req.valid && req.ready;

    assign ctl.start     = accept && (op_t'(req.operation) == OP_TICK);
    assign ctl.ref_write = ref_write;
    assign ctl.queue_len = req.queue_len;

    assign early = (times_ten(req.queue_len) > TEN_W'(cfg_q.queue_ref)) &&
                   (P_W'(req.random_value) < sts.dp);
    assign tail  = (req.queue_len >= cfg_q.queue_limit);

    always_comb
    begin
        valid_next = valid_reg && !result.ready;
        drop_next  = drop_reg;
        cause_next = cause_reg;
        prob_next  = prob_reg;
        if (accept && (op_t'(req.operation) == OP_ARRIVAL))
        begin
            valid_next = 1'b1;
            prob_next  = sts.dp;
            if (early)
            begin
                drop_next  = 1'b1;
                cause_next = CAUSE_EARLY;
            end
            else if (tail)
            begin
                drop_next  = 1'b1;
                cause_next = CAUSE_TAIL;
            end
            else
            begin
                drop_next  = 1'b0;
                cause_next = CAUSE_NONE;
            end
        end
        else if (sts.done)
        begin
            valid_next = 1'b1;
            drop_next  = 1'b0;
            cause_next = CAUSE_NONE;
            prob_next  = sts.dp_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drop_reg  <= drop_next;
        cause_reg <= cause_next;
        prob_reg  <= prob_next;
    end

    assign result.valid      = valid_reg;
    assign result.drop       = drop_reg;
    assign result.drop_cause = cause_reg;
    assign result.drop_rate  = prob_reg;

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> !req.ready)
        else $error("request taken while tick in progress");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (prob_reg <= PROB_ONE_P))
        else $error("drop probability above one");

    a_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (drop_reg == (cause_reg != CAUSE_NONE)))
        else $error("drop flag and cause disagree");

    a_arrival_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(req.operation) == OP_ARRIVAL)) |=> valid_reg)
        else $error("arrival gave no result");

    a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> ##7 sts.done)
        else $error("tick did not finish in eight steps");

endmodule

### hw/rtl/pad_cfg_regs.sv
`timescale 1ns / 1ps

module pad_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    pad_cfg_if.sink       cfg,
    output pad_pkg::cfg_t cfg_q,
    output logic          ref_write
);
    import pad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next  = cfg_reg;
        ref_write = 1'b0;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_QUEUE_REF:
                begin
                    cfg_next.queue_ref = cfg.data[QLEN_BITS-1:0];
                    ref_write          = 1'b1;
                end
                REG_INVERSE_REF: cfg_next.inverse_ref     = cfg.data[INV_W-1:0];
                REG_KP_GAIN:     cfg_next.kp_gain         = cfg.data[GAIN_W-1:0];
                REG_KI_TS_GAIN:  cfg_next.ki_ts_gain      = cfg.data[GAIN_W-1:0];
                REG_KD_TS_GAIN:  cfg_next.kd_over_ts_gain = cfg.data[GAIN_W-1:0];
                REG_QUEUE_LIMIT: cfg_next.queue_limit     = cfg.data[QLEN_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hw/rtl/pad_mul_unit.sv
`timescale 1ns / 1ps

module pad_mul_unit (
    input  logic                                clk,
    input  pad_pkg::mul_req_t                   mul_req,
    output logic signed [pad_pkg::PROD_W-1:0]   mul_res
);
    import pad_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    shift_sel_t               sh_reg;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] biased;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
        sh_reg   <= mul_req.sh;
    end

    // shift right, truncating toward zero
    always_comb
    begin
        case (sh_reg)
            SH_INV:  bias = INV_BIAS;
            SH_GAIN: bias = GAIN_BIAS;
            SH_DIV:  bias = DIV_BIAS;
            default: bias = GAIN_BIAS;
        endcase
        if (!prod_reg[PROD_W-1])
        begin
            bias = '0;
        end
        biased = prod_reg + bias;
        case (sh_reg)
            SH_INV:  mul_res = biased >>> INV_SHIFT;
            SH_GAIN: mul_res = biased >>> GAIN_FRAC;
            SH_DIV:  mul_res = biased >>> DIV_SHIFT;
            default: mul_res = biased >>> GAIN_FRAC;
        endcase
    end

endmodule

### hw/rtl/pad_tick_seq.sv
`timescale 1ns / 1ps

module pad_tick_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  pad_pkg::cfg_t      cfg_q,
    input  pad_pkg::tick_ctl_t ctl,
    output pad_pkg::tick_sts_t sts
);
    import pad_pkg::*;

    tick_state_t state_reg, state_next;

    logic                    gate_reg;
    logic [QLEN_BITS-1:0]    q_reg;
    logic signed [E_W-1:0]   e_reg, e_next;
    logic signed [E_W-1:0]   prev_reg, prev_next;
    logic signed [INT_W-1:0] integ_reg, integ_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic [P_W-1:0]          mag_reg, mag_next;
    logic [P_W-1:0]          dp_reg, dp_next;

    mul_req_t                 mreq;
    logic signed [PROD_W-1:0] mul_res;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DE_W-1:0]   de;
    logic signed [SUM_W-1:0]  isum;
    logic signed [SUM_W-1:0]  rsum;
    logic signed [SUM_W-1:0]  raw;
    logic signed [SUM_W-1:0]  xdiff;
    logic [P_W-1:0]           quot;
    logic                     done;

    pad_mul_unit u_mul (
        .clk     (clk),
        .mul_req (mreq),
        .mul_res (mul_res)
    );

    assign diff  = $signed({1'b0, q_reg}) - $signed({1'b0, cfg_q.queue_ref});
    assign de    = DE_W'(e_reg) - DE_W'(prev_reg);
    assign isum  = SUM_W'(integ_reg) + SUM_W'(mul_res);
    assign rsum  = acc_reg + SUM_W'(mul_res);
    assign xdiff = raw - $signed(SUM_W'(dp_reg));
    assign quot  = P_W'(mul_res);

    always_comb
    begin
        if (rsum < 0)
        begin
            raw = '0;
        end
        else if (rsum > PROB_ONE_S)
        begin
            raw = PROB_ONE_S;
        end
        else
        begin
            raw = rsum;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        prev_next  = prev_reg;
        integ_next = integ_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        dp_next    = dp_reg;
        done       = 1'b0;
        mreq       = '{a: '0, b: '0, sh: SH_GAIN};
        case (state_reg)
            T_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = T_ME;
                end
            end
            T_ME:
            begin
                mreq.a     = MA_W'($signed({1'b0, cfg_q.inverse_ref}));
                mreq.b     = MB_W'(diff);
                mreq.sh    = SH_INV;
                state_next = T_PE;
            end
            T_PE:
            begin
                if (mul_res > ERR_HI)
                begin
                    e_next = E_W'(ERR_HI);
                end
                else if (mul_res < ERR_LO)
                begin
                    e_next = E_W'(ERR_LO);
                end
                else
                begin
                    e_next = E_W'(mul_res);
                end
                state_next = T_MI;
            end
            T_MI:
            begin
                mreq.a     = MA_W'($signed({1'b0, cfg_q.ki_ts_gain}));
                mreq.b     = MB_W'(e_reg);
                mreq.sh    = SH_GAIN;
                state_next = T_MP;
            end
            T_MP:
            begin
                if (gate_reg)
                begin
                    if (isum > INT_HI)
                    begin
                        integ_next = INT_W'(INT_HI);
                    end
                    else if (isum < INT_LO)
                    begin
                        integ_next = INT_W'(INT_LO);
                    end
                    else
                    begin
                        integ_next = INT_W'(isum);
                    end
                end
                mreq.a     = MA_W'($signed({1'b0, cfg_q.kp_gain}));
                mreq.b     = MB_W'(e_reg);
                mreq.sh    = SH_GAIN;
                state_next = T_MD;
            end
            T_MD:
            begin
                acc_next   = SUM_W'(mul_res) + SUM_W'(integ_reg);
                mreq.a     = MA_W'($signed({1'b0, cfg_q.kd_over_ts_gain}));
                mreq.b     = MB_W'(de);
                mreq.sh    = SH_GAIN;
                state_next = T_PD;
            end
            T_PD:
            begin
                neg_next   = xdiff[SUM_W-1];
                mag_next   = xdiff[SUM_W-1] ? P_W'(-xdiff) : P_W'(xdiff);
                prev_next  = e_reg;
                state_next = T_MQ;
            end
            T_MQ:
            begin
                // divide by ten through the reciprocal
                mreq.a     = DIV_MUL_C;
                mreq.b     = MB_W'($signed({1'b0, mag_reg}));
                mreq.sh    = SH_DIV;
                state_next = T_PQ;
            end
            T_PQ:
            begin
                dp_next    = neg_reg ? (dp_reg - quot) : (dp_reg + quot);
                done       = 1'b1;
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
        if (ctl.ref_write)
        begin
            integ_next = '0;
            prev_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            prev_reg  <= '0;
            integ_reg <= '0;
            dp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            integ_reg <= integ_next;
            dp_reg    <= dp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && (state_reg == T_IDLE))
        begin
            q_reg    <= ctl.queue_len;
            gate_reg <= times_ten(ctl.queue_len) >
                        ((TEN_W'(cfg_q.queue_ref) << 1) + TEN_W'(cfg_q.queue_ref));
        end
        e_reg   <= e_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
    end

    assign sts.busy   = (state_reg != T_IDLE);
    assign sts.done   = done;
    assign sts.dp     = dp_reg;
    assign sts.dp_new = dp_next;

endmodule
